@@ hdl/video_chip_raster_registers_core_defines.svh @@
// Assertion macros for the raster register core.
`ifndef VIDEO_CHIP_RASTER_REGISTERS_CORE_DEFINES_SVH
`define VIDEO_CHIP_RASTER_REGISTERS_CORE_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define VCRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raster core check failed");

// Next-cycle implication, gated by reset.
`define VCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raster core check failed");

`endif

@@ hdl/vcrr_pkg.sv @@
`timescale 1ns / 1ps

package vcrr_pkg;

  localparam int unsigned NUM_REGS = 16;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] CFG_CYCLES_PER_LINE  = 2'd0;
  localparam logic [1:0] CFG_LINES_PER_FRAME  = 2'd1;
  localparam logic [1:0] CFG_FIRST_BLANK_LINE = 2'd2;

  localparam logic [3:0] REG_RASTER_HI = 4'd3;
  localparam logic [3:0] REG_RASTER    = 4'd4;
  localparam logic [3:0] REG_PEN_X     = 4'd6;
  localparam logic [3:0] REG_PEN_Y     = 4'd7;
  localparam logic [3:0] REG_PADDLE_X  = 4'd8;
  localparam logic [3:0] REG_PADDLE_Y  = 4'd9;

  localparam logic [7:0] CPL_RESET = 8'd71;
  localparam logic [8:0] LPF_RESET = 9'd312;
  localparam logic [8:0] FBL_RESET = 9'd284;

  typedef logic [7:0] byte_t;
  typedef byte_t reg_file_t [NUM_REGS];

  localparam reg_file_t REG_RESET = '{
    8'h0C, 8'h26, 8'hF0, 8'h16, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B
  };

  typedef struct packed {
    logic       load;
    logic [7:0] elapsed;
    logic       step;
  } ras_ctrl_t;

  typedef struct packed {
    logic        more;
    logic        wrapped;
    logic [8:0]  line;
    logic [31:0] frame;
  } ras_stat_t;

  function automatic logic reg_read_only(input logic [3:0] addr);
    return (addr == REG_RASTER) || (addr == REG_PEN_X) || (addr == REG_PEN_Y) ||
           (addr == REG_PADDLE_X) || (addr == REG_PADDLE_Y);
  endfunction

endpackage

@@ hdl/vcrr_in_if.sv @@
`timescale 1ns / 1ps

interface vcrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] reg_addr;
  logic [7:0] wdata;
  logic [7:0] elapsed_cycles;

  modport source (output valid, func, reg_addr, wdata, elapsed_cycles, input ready);
  modport sink (input valid, func, reg_addr, wdata, elapsed_cycles, output ready);
endinterface

@@ hdl/vcrr_out_if.sv @@
`timescale 1ns / 1ps

interface vcrr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        frame_start;
  logic [8:0]  scanline_now;
  logic [31:0] frame_count;
  logic        in_vblank;

  modport source (output valid, rdata, frame_start, scanline_now, frame_count, in_vblank,
                  input ready);
  modport sink (input valid, rdata, frame_start, scanline_now, frame_count, in_vblank,
                output ready);
endinterface

@@ hdl/vcrr_cfg_if.sv @@
`timescale 1ns / 1ps

interface vcrr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/video_chip_raster_registers_core.sv @@
`timescale 1ns / 1ps
// Raster timing and byte register file of a home-computer video chip.
// in_chan: one item per access; func selects tick, register read or write.
// out_chan: exactly one result item per input item, in order.
// cfg_chan: writes cycles_per_line, lines_per_frame, first_blank_line; always
// ready, to be used only while the core is idle.
// A read or write is accepted in idle, completes in the run state and has its
// result registered; the next item is accepted once the core is back in idle.
// A tick retires the N whole scanlines that its elapsed cycles complete (up to
// 255, or 510 when cycles_per_line is lowered over a large remainder): one
// subtract-and-step unit retires one scanline per cycle. in_chan is not ready
// while an item is in work, so a tick finishes before the next item is taken.
// Results sit in an output register; the next item is accepted while one
// waits. If the receiver stalls, the following item holds at completion
// until the output register is free.
// Reset (synchronous, active low) loads power-on register defaults, clears
// the scanline, frame count and cycle remainder, and restores config defaults.
`include "video_chip_raster_registers_core_defines.svh"
module video_chip_raster_registers_core (
  input logic        clk,
  input logic        rst_n,
  vcrr_in_if.sink    in_chan,
  vcrr_out_if.source out_chan,
  vcrr_cfg_if.sink   cfg_chan
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;

  logic [1:0] func_r;
  logic [3:0] addr_r;
  logic [7:0] wdata_r;

  logic [7:0] cpl_r;
  logic [8:0] lpf_r;
  logic [8:0] fbl_r;

  vcrr_pkg::reg_file_t regs_r, regs_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rdata_r;
  logic        frame_start_r;
  logic [8:0]  scanline_r;
  logic [31:0] frame_r;
  logic        vblank_r;

  vcrr_pkg::ras_ctrl_t ras_ctrl;
  vcrr_pkg::ras_stat_t ras_stat;

  logic in_acc;
  logic is_tick;
  logic finish;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_tick       = (func_r == vcrr_pkg::FUNC_TICK);
  assign finish        = (state_r == S_RUN) && !(is_tick && ras_stat.more) &&
                         (!out_valid_r || out_chan.ready);

  assign ras_ctrl.load    = in_acc && (in_chan.func == vcrr_pkg::FUNC_TICK);
  assign ras_ctrl.elapsed = in_chan.elapsed_cycles;
  assign ras_ctrl.step    = (state_r == S_RUN) && is_tick;

  vcrr_raster u_raster (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ras_ctrl),
    .cycles_per_line (cpl_r),
    .lines_per_frame (lpf_r),
    .stat            (ras_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RUN;
      S_RUN:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    regs_nxt = regs_r;
    if (finish) begin
      if (is_tick) begin
        regs_nxt[vcrr_pkg::REG_RASTER]       = ras_stat.line[7:0];
        regs_nxt[vcrr_pkg::REG_RASTER_HI][0] = ras_stat.line[8];
      end else if ((func_r == vcrr_pkg::FUNC_WRITE) &&
                   !vcrr_pkg::reg_read_only(addr_r)) begin
        regs_nxt[addr_r] = wdata_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      regs_r      <= vcrr_pkg::REG_RESET;
      cpl_r       <= vcrr_pkg::CPL_RESET;
      lpf_r       <= vcrr_pkg::LPF_RESET;
      fbl_r       <= vcrr_pkg::FBL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      regs_r      <= regs_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          vcrr_pkg::CFG_CYCLES_PER_LINE:  cpl_r <= cfg_chan.data[7:0];
          vcrr_pkg::CFG_LINES_PER_FRAME:  lpf_r <= cfg_chan.data;
          vcrr_pkg::CFG_FIRST_BLANK_LINE: fbl_r <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_chan.func;
      addr_r  <= in_chan.reg_addr;
      wdata_r <= in_chan.wdata;
    end
    if (finish) begin
      rdata_r       <= (func_r == vcrr_pkg::FUNC_READ) ? regs_r[addr_r] : 8'h00;
      frame_start_r <= is_tick && ras_stat.wrapped;
      scanline_r    <= ras_stat.line;
      frame_r       <= ras_stat.frame;
      vblank_r      <= (ras_stat.line >= fbl_r);
    end
  end

  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.rdata        = rdata_r;
  assign out_chan.frame_start  = frame_start_r;
  assign out_chan.scanline_now = scanline_r;
  assign out_chan.frame_count  = frame_r;
  assign out_chan.in_vblank    = vblank_r;

  `VCRR_ASSERT_NEXT(a_accept_starts_run, clk, rst_n, in_acc, state_r == S_RUN)
  `VCRR_ASSERT_NOW(a_tick_done_no_line_left, clk, rst_n, finish && is_tick,
                   !ras_stat.more)
  `VCRR_ASSERT_NEXT(a_finish_gives_result, clk, rst_n, finish,
                    out_valid_r && (state_r == S_IDLE))

endmodule

@@ hdl/vcrr_raster.sv @@
`timescale 1ns / 1ps

module vcrr_raster (
  input  logic                clk,
  input  logic                rst_n,
  input  vcrr_pkg::ras_ctrl_t ctrl,
  input  logic [7:0]          cycles_per_line,
  input  logic [8:0]          lines_per_frame,
  output vcrr_pkg::ras_stat_t stat
);

  logic [8:0]  acc_r, acc_nxt;
  logic [8:0]  line_r, line_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic        wrapped_r, wrapped_nxt;

  logic [8:0]  cpl_eff;
  logic [9:0]  lpf_eff;
  logic [9:0]  line_inc;
  logic        wrap;
  logic        more;

  assign cpl_eff  = {(cycles_per_line == 8'd0), cycles_per_line};
  assign lpf_eff  = {(lines_per_frame == 9'd0), lines_per_frame};
  assign line_inc = {1'b0, line_r} + 10'd1;
  assign wrap     = (line_inc >= lpf_eff);
  assign more     = (acc_r >= cpl_eff);

  always_comb begin
    acc_nxt     = acc_r;
    line_nxt    = line_r;
    frame_nxt   = frame_r;
    wrapped_nxt = wrapped_r;
    if (ctrl.load) begin
      acc_nxt     = acc_r + {1'b0, ctrl.elapsed};
      wrapped_nxt = 1'b0;
    end else if (ctrl.step && more) begin
      acc_nxt = acc_r - cpl_eff;
      if (wrap) begin
        line_nxt    = '0;
        frame_nxt   = frame_r + 32'd1;
        wrapped_nxt = 1'b1;
      end else begin
        line_nxt = line_inc[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      line_r    <= '0;
      frame_r   <= '0;
      wrapped_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      line_r    <= line_nxt;
      frame_r   <= frame_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  assign stat.more    = more;
  assign stat.wrapped = wrapped_r;
  assign stat.line    = line_r;
  assign stat.frame   = frame_r;

endmodule
